// ----- design/shell_line_syntax_check_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the shell line syntax checker
// Shared helpers for concurrent checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_SYNTAX_CHECK_DEFINES_SVH
`define SHELL_LINE_SYNTAX_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SLSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- design/slsc_pkg.sv -----
// ----------------------------------------------------------------------------
// slsc_pkg
// Types and constants shared by the shell line syntax checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slsc_pkg;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Classified character, as it travels from the front to the back.
    typedef struct packed {
        logic is_end;
        logic is_space;
        logic is_redir;
        logic is_gt;
        logic is_pipe;
        logic is_squote;
        logic is_dquote;
        logic is_forbidden;
    } t_char_class;

    typedef enum logic [1:0] {
        REDIR_IDLE = 2'd0,
        REDIR_JUST = 2'd1,
        REDIR_SKIP = 2'd2
    } t_redir_phase;

    typedef enum logic [1:0] {
        TOK_NONE    = 2'd0,
        TOK_NOTOKEN = 2'd1,
        TOK_PIPE    = 2'd2,
        TOK_NEWLINE = 2'd3
    } t_token;

    typedef enum logic [1:0] {
        CHK_NONE  = 2'd0,
        CHK_QUOTE = 2'd1,
        CHK_PIPE  = 2'd2,
        CHK_REDIR = 2'd3
    } t_check;

endpackage

`default_nettype wire

// ----- design/slsc_front.sv -----
// ----------------------------------------------------------------------------
// slsc_front
// Accepts characters and registers their classification for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module slsc_front
    import slsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output t_char_class      o_class
);

    logic        r_valid;
    t_char_class r_class;
    t_char_class n_class;
    logic        accept;

    always_comb begin
        n_class              = '0;
        n_class.is_end       = (i_character == CH_END);
        n_class.is_space     = (i_character == CH_SPACE) ||
                               (i_character inside {[CH_TAB:CH_CR]});
        n_class.is_redir     = (i_character == CH_LT) || (i_character == CH_GT);
        n_class.is_gt        = (i_character == CH_GT);
        n_class.is_pipe      = (i_character == CH_PIPE);
        n_class.is_squote    = (i_character == CH_SQUOTE);
        n_class.is_dquote    = (i_character == CH_DQUOTE);
        n_class.is_forbidden = (i_character == CH_BSLASH) || (i_character == CH_SEMI);
    end

    assign o_push  = r_valid && !i_queue_full;
    assign o_stall = r_valid && i_queue_full;
    assign accept  = i_valid && !o_stall;
    assign o_class = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_class <= n_class;
        end
    end

endmodule

`default_nettype wire

// ----- design/slsc_queue.sv -----
// ----------------------------------------------------------------------------
// slsc_queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_line_syntax_check_defines.svh"

module slsc_queue
    import slsc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_char_class i_class,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_not_empty,
    output t_char_class      o_class
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_char_class      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_class     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_class;
        end
    end

    `SLSC_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `SLSC_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SLSC_ASSERT_NEXT(a_push_only_grows, i_clk, i_rst_n, i_push && !i_pop,
                      r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

// ----- design/slsc_back.sv -----
// ----------------------------------------------------------------------------
// slsc_back
// Runs the quote, pipe and redirection rules and registers the line result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_line_syntax_check_defines.svh"

module slsc_back
    import slsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_not_empty,
    input  wire t_char_class i_class,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_syntax_ok,
    output logic [1:0]       o_failed_check,
    output logic [1:0]       o_error_token
);

    logic         r_sq, n_sq;
    logic         r_dq, n_dq;
    logic         r_only_spaces, n_only_spaces;
    logic         r_await_pipe, n_await_pipe;
    t_redir_phase r_phase, n_phase;
    logic         r_first_gt, n_first_gt;
    logic         r_quote_fault, n_quote_fault;
    logic         r_pipe_fault, n_pipe_fault;
    t_token       r_rtok, n_rtok;

    logic         r_out_valid;
    logic         r_ok;
    t_check       r_check;
    t_token       r_tok;
    logic         res_ok;
    t_check       res_check;
    t_token       res_tok;
    t_token       end_rtok;

    logic         out_free;
    logic         lead;
    logic         outside;
    logic         end_pop;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_not_empty && (!i_class.is_end || out_free);
    assign end_pop  = o_pop && i_class.is_end;

    // Next state of the line trackers.
    always_comb begin
        n_sq          = r_sq;
        n_dq          = r_dq;
        n_only_spaces = r_only_spaces;
        n_await_pipe  = r_await_pipe;
        n_phase       = r_phase;
        n_first_gt    = r_first_gt;
        n_quote_fault = r_quote_fault;
        n_pipe_fault  = r_pipe_fault;
        n_rtok        = r_rtok;
        lead          = r_only_spaces && !i_class.is_space;
        outside       = 1'b1;
        if (i_class.is_end) begin
            n_sq          = 1'b0;
            n_dq          = 1'b0;
            n_only_spaces = 1'b1;
            n_await_pipe  = 1'b0;
            n_phase       = REDIR_IDLE;
            n_first_gt    = 1'b0;
            n_quote_fault = 1'b0;
            n_pipe_fault  = 1'b0;
            n_rtok        = TOK_NONE;
        end else begin
            n_sq    = r_sq ^ (i_class.is_squote && !r_dq);
            n_dq    = r_dq ^ (i_class.is_dquote && !r_sq);
            outside = !n_sq && !n_dq;

            if (i_class.is_forbidden && outside) begin
                n_quote_fault = 1'b1;
            end

            if (!r_pipe_fault) begin
                if (r_await_pipe && i_class.is_space) begin
                    n_await_pipe = 1'b1;
                end else if (i_class.is_pipe && outside) begin
                    if (lead || r_await_pipe) begin
                        n_pipe_fault = 1'b1;
                        n_await_pipe = 1'b0;
                    end else begin
                        n_await_pipe = 1'b1;
                    end
                end else begin
                    n_await_pipe = 1'b0;
                end
            end

            if (r_rtok == TOK_NONE) begin
                if (lead && i_class.is_redir) begin
                    n_rtok  = TOK_NEWLINE;
                    n_phase = REDIR_IDLE;
                end else if (r_phase == REDIR_JUST && i_class.is_redir &&
                             (i_class.is_gt == r_first_gt)) begin
                    n_phase = REDIR_SKIP;
                end else if (r_phase != REDIR_IDLE) begin
                    if (i_class.is_space) begin
                        n_phase = REDIR_SKIP;
                    end else if (i_class.is_pipe) begin
                        n_rtok  = TOK_PIPE;
                        n_phase = REDIR_IDLE;
                    end else if (i_class.is_redir) begin
                        n_rtok  = TOK_NEWLINE;
                        n_phase = REDIR_IDLE;
                    end else begin
                        n_phase = REDIR_IDLE;
                    end
                end else if (i_class.is_redir && outside) begin
                    n_phase    = REDIR_JUST;
                    n_first_gt = i_class.is_gt;
                end
            end

            if (!i_class.is_space) begin
                n_only_spaces = 1'b0;
            end
        end
    end

    // Line result, priority quotes, then pipes, then redirections.
    always_comb begin
        end_rtok  = r_rtok;
        res_ok    = 1'b0;
        res_check = CHK_NONE;
        res_tok   = TOK_NONE;
        if (r_rtok == TOK_NONE && r_phase != REDIR_IDLE) begin
            end_rtok = TOK_NEWLINE;
        end
        if (r_quote_fault || r_sq || r_dq) begin
            res_check = CHK_QUOTE;
            res_tok   = TOK_NOTOKEN;
        end else if (r_pipe_fault || r_await_pipe) begin
            res_check = CHK_PIPE;
            res_tok   = TOK_PIPE;
        end else if (end_rtok != TOK_NONE) begin
            res_check = CHK_REDIR;
            res_tok   = end_rtok;
        end else begin
            res_ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq          <= 1'b0;
            r_dq          <= 1'b0;
            r_only_spaces <= 1'b1;
            r_await_pipe  <= 1'b0;
            r_phase       <= REDIR_IDLE;
            r_first_gt    <= 1'b0;
            r_quote_fault <= 1'b0;
            r_pipe_fault  <= 1'b0;
            r_rtok        <= TOK_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sq          <= n_sq;
                r_dq          <= n_dq;
                r_only_spaces <= n_only_spaces;
                r_await_pipe  <= n_await_pipe;
                r_phase       <= n_phase;
                r_first_gt    <= n_first_gt;
                r_quote_fault <= n_quote_fault;
                r_pipe_fault  <= n_pipe_fault;
                r_rtok        <= n_rtok;
            end
            if (end_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_pop) begin
            r_ok    <= res_ok;
            r_check <= res_check;
            r_tok   <= res_tok;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_syntax_ok    = r_ok;
    assign o_failed_check = r_check;
    assign o_error_token  = r_tok;

    `SLSC_ASSERT_NEXT(a_end_clears_line, i_clk, i_rst_n, end_pop,
                      r_out_valid && r_only_spaces && !r_sq && !r_dq)
    `SLSC_ASSERT_SAME(a_ok_means_clean, i_clk, i_rst_n, r_out_valid && r_ok,
                      r_check == CHK_NONE && r_tok == TOK_NONE)
    `SLSC_ASSERT_SAME(a_pipe_fault_no_wait, i_clk, i_rst_n, r_pipe_fault, !r_await_pipe)

endmodule

`default_nettype wire

// ----- design/shell_line_syntax_check.sv -----
// ----------------------------------------------------------------------------
// shell_line_syntax_check
// Checks shell command lines for quote, pipe and redirection errors.
// ----------------------------------------------------------------------------
// Characters of a command line enter on i_character with i_valid; an item is
// taken at a clock edge where i_valid is high and o_stall is low. A zero byte
// ends the line. Only the end byte produces a result: o_syntax_ok,
// o_failed_check and o_error_token are shown with o_valid and are taken at an
// edge where o_valid is high and i_stall is low; all other characters produce
// nothing on the output side.
// Throughput is one character per clock cycle while o_stall is low. The
// result of an end byte passes through the front classification register
// and the queue before it is held in the back output register. The back
// updates its line state once for each character it pops, which sets the
// rate. While the receiver stalls, characters that are not end bytes keep
// flowing through the back; an end byte waits at the head of the queue, and
// o_stall rises once the queue holds QUEUE_DEPTH items and one more waits in
// the front register.
// Synchronous reset clears the queue, the output register and the line state,
// so the block starts at the beginning of a fresh line.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_line_syntax_check
    import slsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_syntax_ok,
    output logic [1:0]       o_failed_check,
    output logic [1:0]       o_error_token
);

    t_char_class front_class;
    t_char_class queue_class;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_not_empty;

    slsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_character  (i_character),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_class      (front_class)
    );

    slsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_class     (front_class),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_class     (queue_class)
    );

    slsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_not_empty    (queue_not_empty),
        .i_class        (queue_class),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_syntax_ok    (o_syntax_ok),
        .o_failed_check (o_failed_check),
        .o_error_token  (o_error_token)
    );

endmodule

`default_nettype wire

// ----- verif/shell_line_syntax_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_line_syntax_check_tb
// Feeds command lines byte by byte into the syntax checker and compares each
// verdict that comes out on an end byte with one worked out in the bench from
// the same bytes. Both sides idle and stall at random, with a long output
// stall that fills the block and a pause that lets it drain.
// ----------------------------------------------------------------------------

module shell_line_syntax_check_tb;
    import slsc_pkg::*;

    typedef struct packed {
        logic   ok;
        t_check chk;
        t_token tok;
    } t_line_verdict;

    // Tracks the state of the line being fed and holds the verdicts still due.
    class t_verdict_board;
        bit            in_sq;
        bit            in_dq;
        bit            only_sp;
        bit            pipe_wait;
        bit            pipe_bad;
        bit            quote_bad;
        t_redir_phase  rphase;
        bit            redir_gt;
        t_token        redir_tok;
        t_line_verdict open_verdicts[$];
        int            mismatches;

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            in_sq     = 1'b0;
            in_dq     = 1'b0;
            only_sp   = 1'b1;
            pipe_wait = 1'b0;
            pipe_bad  = 1'b0;
            quote_bad = 1'b0;
            rphase    = REDIR_IDLE;
            redir_gt  = 1'b0;
            redir_tok = TOK_NONE;
        endfunction

        function int pending();
            return open_verdicts.size();
        endfunction

        function void scan_char(logic [7:0] c);
            bit            sp;
            bit            rd;
            bit            gt;
            bit            lead;
            bit            outside;
            t_token        rt;
            t_line_verdict v;
            if (c == CH_END) begin
                rt = redir_tok;
                // A redirection still waiting for its target counts as newline.
                if (rt == TOK_NONE && rphase != REDIR_IDLE)
                    rt = TOK_NEWLINE;
                v.ok = 1'b0;
                if (quote_bad || in_sq || in_dq) begin
                    v.chk = CHK_QUOTE;
                    v.tok = TOK_NOTOKEN;
                end else if (pipe_bad || pipe_wait) begin
                    v.chk = CHK_PIPE;
                    v.tok = TOK_PIPE;
                end else if (rt != TOK_NONE) begin
                    v.chk = CHK_REDIR;
                    v.tok = rt;
                end else begin
                    v.ok  = 1'b1;
                    v.chk = CHK_NONE;
                    v.tok = TOK_NONE;
                end
                open_verdicts.push_back(v);
                clear_line();
                return;
            end
            sp   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            rd   = (c == CH_LT) || (c == CH_GT);
            gt   = (c == CH_GT);
            lead = only_sp && !sp;
            if (c == CH_SQUOTE && !in_dq)
                in_sq = !in_sq;
            else if (c == CH_DQUOTE && !in_sq)
                in_dq = !in_dq;
            outside = !in_sq && !in_dq;
            if ((c == CH_BSLASH || c == CH_SEMI) && outside)
                quote_bad = 1'b1;
            // Spaces after a pipe keep the wait open.
            if (!pipe_bad && !(pipe_wait && sp)) begin
                if (c == CH_PIPE && outside) begin
                    if (lead || pipe_wait) begin
                        pipe_bad  = 1'b1;
                        pipe_wait = 1'b0;
                    end else begin
                        pipe_wait = 1'b1;
                    end
                end else begin
                    pipe_wait = 1'b0;
                end
            end
            if (redir_tok == TOK_NONE) begin
                if (lead && rd) begin
                    redir_tok = TOK_NEWLINE;
                    rphase    = REDIR_IDLE;
                end else if (rphase == REDIR_JUST && rd && gt == redir_gt) begin
                    rphase = REDIR_SKIP;
                end else if (rphase != REDIR_IDLE) begin
                    if (sp) begin
                        rphase = REDIR_SKIP;
                    end else if (c == CH_PIPE) begin
                        redir_tok = TOK_PIPE;
                        rphase    = REDIR_IDLE;
                    end else if (rd) begin
                        redir_tok = TOK_NEWLINE;
                        rphase    = REDIR_IDLE;
                    end else begin
                        rphase = REDIR_IDLE;
                    end
                end else if (rd && outside) begin
                    rphase   = REDIR_JUST;
                    redir_gt = gt;
                end
            end
            if (!sp)
                only_sp = 1'b0;
        endfunction

        function void check_verdict(logic ok, logic [1:0] chk, logic [1:0] tok);
            t_line_verdict want;
            if (open_verdicts.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected verdict: ok=%0d check=%0d token=%0d",
                             ok, chk, tok);
                mismatches++;
                return;
            end
            want = open_verdicts.pop_front();
            if (ok !== want.ok || chk !== want.chk || tok !== want.tok) begin
                if (mismatches < 10)
                    $display({"verdict mismatch: expected ok=%0d check=%0d token=%0d,",
                              " got ok=%0d check=%0d token=%0d"},
                             want.ok, want.chk, want.tok, ok, chk, tok);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic [7:0] i_character = 8'h00;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_syntax_ok;
    logic [1:0] o_failed_check;
    logic [1:0] o_error_token;

    t_verdict_board board;
    bit             idle_on = 1'b1;
    int             hold_left = 0;
    int             stall_left = 0;
    logic [7:0]     line_buf[$];

    shell_line_syntax_check DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_character    (i_character),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_syntax_ok    (o_syntax_ok),
        .o_failed_check (o_failed_check),
        .o_error_token  (o_error_token)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: a long hold when one is set, else short random bursts.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_verdict(o_syntax_ok, o_failed_check, o_error_token);
    end

    task automatic send_char(input logic [7:0] c);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= c;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.scan_char(c);
    endtask

    task automatic send_line(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k]);
        send_char(CH_END);
    endtask

    task automatic send_buffered();
        foreach (line_buf[k])
            send_char(line_buf[k]);
        send_char(CH_END);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_word();
        repeat ($urandom_range(1, 5))
            line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
    endtask

    // Builds a line mostly from words, spaces, pipes, redirections and
    // quoted parts; a small share is forbidden characters and raw bytes.
    task automatic make_line(input int max_tokens);
        logic [7:0] qc;
        line_buf.delete();
        repeat ($urandom_range(0, max_tokens)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 14: push_word();
                4, 5: begin
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back($urandom_range(0, 3) == 0 ?
                                           8'($urandom_range(9, 13)) : CH_SPACE);
                end
                6, 7: line_buf.push_back(CH_PIPE);
                8, 9: begin
                    qc = $urandom_range(0, 1) ? CH_GT : CH_LT;
                    line_buf.push_back(qc);
                    if ($urandom_range(0, 2) == 0)
                        line_buf.push_back($urandom_range(0, 3) == 0 ? CH_LT ^ CH_GT ^ qc : qc);
                end
                10: begin
                    qc = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                    line_buf.push_back(qc);
                    repeat ($urandom_range(0, 4)) begin
                        case ($urandom_range(0, 7))
                            0: line_buf.push_back(CH_PIPE);
                            1: line_buf.push_back(CH_SEMI);
                            2: line_buf.push_back(CH_BSLASH);
                            3: line_buf.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
                            4: line_buf.push_back(CH_SQUOTE ^ CH_DQUOTE ^ qc);
                            5: line_buf.push_back(CH_SPACE);
                            default: line_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
                        endcase
                    end
                    if ($urandom_range(0, 9) != 0)
                        line_buf.push_back(qc);
                end
                11: line_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                12: line_buf.push_back($urandom_range(0, 1) ? CH_SEMI : CH_BSLASH);
                default: line_buf.push_back(8'($urandom_range(1, 255)));
            endcase
        end
    endtask

    initial begin
        int chars_sent;
        int lines_sent;
        board = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_line("");
        send_line(" \011\015");
        send_line("a|b");
        send_line(" |a");
        send_line("a| |");
        send_line("> f");
        send_line("a>> |");
        send_line("a<>b");
        send_line("a >");
        send_line("|'");
        send_line("\"'\"\\");
        send_line("a;");
        send_line("<|");
        send_line("x\377\001'>|'");

        // Hold the output long enough that end bytes back up and the input
        // side stalls, then let everything drain with the sender quiet.
        wait_drained();
        idle_on   = 1'b0;
        hold_left = 80;
        repeat (16) begin
            make_line(2);
            send_buffered();
        end
        wait_drained();
        repeat ($urandom_range(5, 20)) @(negedge i_clk);

        chars_sent = 0;
        lines_sent = 0;
        idle_on    = 1'b1;
        while (chars_sent < 260 || lines_sent < 26) begin
            if (lines_sent % 8 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            make_line(8);
            chars_sent += line_buf.size() + 1;
            lines_sent++;
            send_buffered();
        end

        idle_on = 1'b0;
        repeat (10) begin
            make_line(4);
            send_buffered();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
